// ----- rtl/gtp_pkg.sv -----
// Shared types, constants and table functions for the go-to-point steering controller.
// Used by every module in rtl/; depends on nothing else.
package gtp_pkg;

	localparam int XW = 36;
	localparam int DW = 35;
	localparam int WRAP_W = 35;
	localparam int DIV_BITS = 31;
	localparam int MAX_STAGES = 24;
	localparam logic [63:0] PI_TRUE_Q30 = 64'd3373259426;
	localparam logic [27:0] KINV_Q28 = 28'd163008219;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_DIST_TOL = 3'd0;
	localparam cfg_idx_t CFG_HEAD_TOL = 3'd1;
	localparam cfg_idx_t CFG_MAX_TURN = 3'd2;
	localparam cfg_idx_t CFG_TURN_FS = 3'd3;
	localparam cfg_idx_t CFG_MAX_SPEED = 3'd4;
	localparam cfg_idx_t CFG_SPEED_FS = 3'd5;

	typedef enum logic [2:0] {
		MODE_REACHED = 3'd0,
		MODE_CANCELLED = 3'd1,
		MODE_ABORTED = 3'd2,
		MODE_FIX_HEADING = 3'd3,
		MODE_DRIVE = 3'd4
	} mode_t;

	typedef struct packed {
		logic [31:0] th;
		logic [31:0] ph;
		logic cancel;
		logic active;
	} pose_side_t;

	typedef struct packed {
		logic [DW-1:0] distance;
		logic near;
		logic cancel;
		logic active;
	} wrap_side_t;

	typedef struct packed {
		mode_t mode;
		logic tsat;
		logic ssat;
		logic neg;
		logic zero;
	} div_side_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h3243F6A8;
			1: r = 32'h1DAC6705;
			2: r = 32'h0FADBAFC;
			3: r = 32'h07F56EA6;
			4: r = 32'h03FEAB76;
			5: r = 32'h01FFD55B;
			6: r = 32'h00FFFAAA;
			7: r = 32'h007FFF55;
			8: r = 32'h003FFFEA;
			9: r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] q30_to_frac(input logic [63:0] v, input int frac);
		logic [63:0] r;
		r = (v + (64'd1 << (29 - frac))) >> (30 - frac);
		return r[31:0];
	endfunction

endpackage

// ----- rtl/gtp_cordic_cell.sv -----
// One CORDIC vectoring stage: rotates toward y = 0 and accumulates the angle.
// Depends on gtp_pkg for the vector width.
module gtp_cordic_cell #(
	parameter int STAGE = 0,
	parameter int ZW = 21,
	parameter logic [ZW-1:0] ATAN = '0
) (
	input logic clk,
	input logic signed [gtp_pkg::XW-1:0] x_in,
	input logic signed [gtp_pkg::XW-1:0] y_in,
	input logic signed [ZW-1:0] z_in,
	output logic signed [gtp_pkg::XW-1:0] x_out,
	output logic signed [gtp_pkg::XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out
);
	import gtp_pkg::*;

	logic signed [XW-1:0] xs, ys, x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic pos;

	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;
	assign pos = ~y_in[XW-1] & (|y_in);

	always_ff @(posedge clk) begin
		if (pos) begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			z_q <= z_in + $signed(ATAN);
		end else begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			z_q <= z_in - $signed(ATAN);
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule

// ----- rtl/gtp_wrap_cell.sv -----
// One restoring reduction step of the angle wrap: subtracts a fixed multiple of 2*pi if it fits.
// Depends on gtp_pkg for the word width.
module gtp_wrap_cell #(
	parameter logic [gtp_pkg::WRAP_W-1:0] STEP = '0
) (
	input logic clk,
	input logic [gtp_pkg::WRAP_W-1:0] v_in,
	output logic [gtp_pkg::WRAP_W-1:0] v_out
);
	import gtp_pkg::*;

	logic [WRAP_W-1:0] v_q;

	always_ff @(posedge clk) begin
		if (v_in >= STEP) begin
			v_q <= v_in - STEP;
		end else begin
			v_q <= v_in;
		end
	end

	assign v_out = v_q;
endmodule

// ----- rtl/gtp_div_cell.sv -----
// One restoring long-division step producing one quotient bit per cycle.
// Depends on gtp_pkg for the quotient width.
module gtp_div_cell (
	input logic clk,
	input logic [gtp_pkg::DIV_BITS-1:0] divisor,
	input logic [gtp_pkg::DIV_BITS-1:0] rem_in,
	input logic [gtp_pkg::DIV_BITS-1:0] num_in,
	input logic [gtp_pkg::DIV_BITS-1:0] quo_in,
	output logic [gtp_pkg::DIV_BITS-1:0] rem_out,
	output logic [gtp_pkg::DIV_BITS-1:0] num_out,
	output logic [gtp_pkg::DIV_BITS-1:0] quo_out
);
	import gtp_pkg::*;

	logic [DIV_BITS:0] r2, diff;
	logic ge;
	logic [DIV_BITS-1:0] rem_q, num_q, quo_q;

	assign r2 = {rem_in, num_in[DIV_BITS-1]};
	assign diff = r2 - {1'b0, divisor};
	assign ge = r2 >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[DIV_BITS-1:0] : r2[DIV_BITS-1:0];
		num_q <= {num_in[DIV_BITS-2:0], 1'b0};
		quo_q <= {quo_in[DIV_BITS-2:0], ge};
	end

	assign rem_out = rem_q;
	assign num_out = num_q;
	assign quo_out = quo_q;
endmodule

// ----- rtl/go_to_point_steering_controller.sv -----
// Go-to-point steering controller: CORDIC bearing and distance, heading wrap, mode and commands.
// Pipeline: input registers, CORDIC stages, distance and error stages, wrap steps, mode stages,
// divider steps, output register; wrap steps: as many halvings of 2*pi as cover the error range.
// One tick is taken every cycle; busy stays low, the receiver cannot stall and done pulses once.
// Reset clears the valid line and loads the configuration registers with their defaults.
// Uses gtp_pkg and the cordic, wrap and divider cells.
module go_to_point_steering_controller #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] target_x,
	input logic signed [31:0] target_y,
	input logic signed [31:0] target_heading,
	input logic signed [31:0] pose_x,
	input logic signed [31:0] pose_y,
	input logic signed [31:0] pose_heading,
	input logic cancel_requested,
	input logic goal_active,
	input logic cfg_valid,
	output logic cfg_ready,
	input gtp_pkg::cfg_idx_t cfg_index,
	input logic [31:0] cfg_data,
	output logic done,
	output gtp_pkg::mode_t mode,
	output logic signed [31:0] turn_command,
	output logic signed [31:0] speed_command,
	output logic finished,
	output logic succeeded
);
	import gtp_pkg::*;

	localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int ZW = FRAC_BITS + 5;
	localparam int AW = FRAC_BITS + 3;
	localparam longint P_VAL = (64'sd31416 * (64'sd1 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000;
	localparam longint TWO_P = 2 * P_VAL;
	localparam int RED = $clog2(((64'sd1 <<< 33) + TWO_P - 1) / TWO_P);
	localparam longint M_VAL = TWO_P <<< RED;
	localparam int NW = RED + 1;
	localparam int LAT = 2 + NS + 6 + NW + DIV_BITS + 1;
	localparam logic [ZW-1:0] PI_Z = ZW'(q30_to_frac(PI_TRUE_Q30, FRAC_BITS));
	localparam logic [WRAP_W-1:0] P_W = WRAP_W'(P_VAL);

	logic accept;
	logic [LAT-1:0] vld_q;
	logic [30:0] dtol_q, htol_q, mtr_q, tfs_q, mfs_q, sfs_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtol_q <= 31'd3277;
			htol_q <= 31'd3277;
			mtr_q <= 31'd32768;
			tfs_q <= 31'd65536;
			mfs_q <= 31'd13107;
			sfs_q <= 31'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIST_TOL: dtol_q <= cfg_data[30:0];
				CFG_HEAD_TOL: htol_q <= cfg_data[30:0];
				CFG_MAX_TURN: mtr_q <= cfg_data[30:0];
				CFG_TURN_FS: tfs_q <= cfg_data[30:0];
				CFG_MAX_SPEED: mfs_q <= cfg_data[30:0];
				CFG_SPEED_FS: sfs_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	logic signed [32:0] dx_s1, dy_s1;
	pose_side_t side_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= {target_x[31], target_x} - {pose_x[31], pose_x};
		dy_s1 <= {target_y[31], target_y} - {pose_y[31], pose_y};
		side_s1 <= '{th: target_heading, ph: pose_heading,
			cancel: cancel_requested, active: goal_active};
	end

	logic signed [XW-1:0] cx [0:NS];
	logic signed [XW-1:0] cy [0:NS];
	logic signed [ZW-1:0] cz [0:NS];
	pose_side_t cside [0:NS];
	logic signed [XW-1:0] dx_ext, dy_ext;

	assign dx_ext = {{(XW-33){dx_s1[32]}}, dx_s1};
	assign dy_ext = {{(XW-33){dy_s1[32]}}, dy_s1};

	always_ff @(posedge clk) begin
		if (dx_s1[32]) begin
			cx[0] <= -dx_ext;
			cy[0] <= -dy_ext;
			cz[0] <= dy_s1[32] ? -$signed(PI_Z) : $signed(PI_Z);
		end else begin
			cx[0] <= dx_ext;
			cy[0] <= dy_ext;
			cz[0] <= '0;
		end
		cside[0] <= side_s1;
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		gtp_cordic_cell #(
			.STAGE(i),
			.ZW(ZW),
			.ATAN(ZW'(q30_to_frac({32'd0, atan_q30(i)}, FRAC_BITS)))
		) u_cell (
			.clk(clk),
			.x_in(cx[i]),
			.y_in(cy[i]),
			.z_in(cz[i]),
			.x_out(cx[i+1]),
			.y_out(cy[i+1]),
			.z_out(cz[i+1])
		);
		always_ff @(posedge clk) begin
			cside[i+1] <= cside[i];
		end
	end

	logic [DW-1:0] xpos;
	logic [45:0] hi_m1;
	logic [44:0] lo_m1;
	logic signed [ZW-1:0] z_m1, z_m2;
	pose_side_t side_m1, side_m2;
	logic [63:0] dsum;
	logic [DW-1:0] dist_m2;

	assign xpos = cx[NS][XW-1] ? '0 : cx[NS][DW-1:0];
	assign dsum = {1'b0, hi_m1, 17'd0} + {19'd0, lo_m1} + (64'd1 << 27);

	always_ff @(posedge clk) begin
		hi_m1 <= xpos[34:17] * KINV_Q28;
		lo_m1 <= xpos[16:0] * KINV_Q28;
		z_m1 <= cz[NS];
		side_m1 <= cside[NS];
		dist_m2 <= dsum[28 +: DW];
		z_m2 <= z_m1;
		side_m2 <= side_m1;
	end

	logic near;
	logic signed [33:0] desired;
	logic signed [33:0] e_d1;
	wrap_side_t side_d1;
	logic signed [35:0] s_sum, s_adj;
	logic [WRAP_W-1:0] wv [0:NW];
	wrap_side_t wside [0:NW];

	assign near = dist_m2 <= {4'd0, dtol_q};
	assign desired = near ? {{2{side_m2.th[31]}}, side_m2.th} : {{(34-ZW){z_m2[ZW-1]}}, z_m2};
	assign s_sum = {{2{e_d1[33]}}, e_d1} + 36'(P_VAL);
	assign s_adj = s_sum[35] ? s_sum + 36'(M_VAL) : s_sum;

	always_ff @(posedge clk) begin
		e_d1 <= desired - {{2{side_m2.ph[31]}}, side_m2.ph};
		side_d1 <= '{distance: dist_m2, near: near, cancel: side_m2.cancel,
			active: side_m2.active};
		wv[0] <= s_adj[WRAP_W-1:0];
		wside[0] <= side_d1;
	end

	for (genvar k = 0; k < NW; k++) begin : g_wrap
		gtp_wrap_cell #(
			.STEP(WRAP_W'(TWO_P <<< (RED - k)))
		) u_cell (
			.clk(clk),
			.v_in(wv[k]),
			.v_out(wv[k+1])
		);
		always_ff @(posedge clk) begin
			wside[k+1] <= wside[k];
		end
	end

	logic [WRAP_W-1:0] r_w;
	logic r_ge;
	logic [AW-1:0] aerr_f1;
	logic neg_f1, zero_f1;
	wrap_side_t side_f1;

	assign r_w = wv[NW];
	assign r_ge = r_w >= P_W;

	always_ff @(posedge clk) begin
		aerr_f1 <= r_ge ? AW'(r_w - P_W) : AW'(P_W - r_w);
		neg_f1 <= ~r_ge;
		zero_f1 <= r_w == P_W;
		side_f1 <= wside[NW];
	end

	mode_t mode_c;
	logic aligned;
	logic [30:0] aerr31;
	logic [61:0] nt_f2, ns_f2;
	div_side_t side_f2;

	assign aerr31 = 31'(aerr_f1);
	assign aligned = aerr31 <= htol_q;

	always_comb begin
		if (side_f1.near && aligned) begin
			mode_c = MODE_REACHED;
		end else if (side_f1.cancel) begin
			mode_c = MODE_CANCELLED;
		end else if (!side_f1.active) begin
			mode_c = MODE_ABORTED;
		end else if (!aligned) begin
			mode_c = MODE_FIX_HEADING;
		end else begin
			mode_c = MODE_DRIVE;
		end
	end

	always_ff @(posedge clk) begin
		nt_f2 <= aerr31 * mtr_q;
		ns_f2 <= side_f1.distance[30:0] * mfs_q;
		side_f2 <= '{mode: mode_c, tsat: aerr31 >= tfs_q,
			ssat: side_f1.distance >= {4'd0, sfs_q}, neg: neg_f1, zero: zero_f1};
	end

	logic [DIV_BITS-1:0] trem [0:DIV_BITS];
	logic [DIV_BITS-1:0] tnum [0:DIV_BITS];
	logic [DIV_BITS-1:0] tquo [0:DIV_BITS];
	logic [DIV_BITS-1:0] srem [0:DIV_BITS];
	logic [DIV_BITS-1:0] snum [0:DIV_BITS];
	logic [DIV_BITS-1:0] squo [0:DIV_BITS];
	div_side_t dside [0:DIV_BITS];
	logic active_f2;
	logic dactive [0:DIV_BITS];

	assign trem[0] = nt_f2[61:31];
	assign tnum[0] = nt_f2[30:0];
	assign tquo[0] = '0;
	assign srem[0] = ns_f2[61:31];
	assign snum[0] = ns_f2[30:0];
	assign squo[0] = '0;
	assign dside[0] = side_f2;
	assign dactive[0] = active_f2;

	always_ff @(posedge clk) begin
		active_f2 <= side_f1.active;
	end

	for (genvar b = 0; b < DIV_BITS; b++) begin : g_div
		gtp_div_cell u_turn (
			.clk(clk),
			.divisor(tfs_q),
			.rem_in(trem[b]),
			.num_in(tnum[b]),
			.quo_in(tquo[b]),
			.rem_out(trem[b+1]),
			.num_out(tnum[b+1]),
			.quo_out(tquo[b+1])
		);
		gtp_div_cell u_speed (
			.clk(clk),
			.divisor(sfs_q),
			.rem_in(srem[b]),
			.num_in(snum[b]),
			.quo_in(squo[b]),
			.rem_out(srem[b+1]),
			.num_out(snum[b+1]),
			.quo_out(squo[b+1])
		);
		always_ff @(posedge clk) begin
			dside[b+1] <= dside[b];
			dactive[b+1] <= dactive[b];
		end
	end

	div_side_t fin;
	logic [30:0] turn_mag, speed_mag;
	logic signed [31:0] turn_c, speed_c;
	logic steer;

	assign fin = dside[DIV_BITS];
	assign turn_mag = fin.tsat ? mtr_q : tquo[DIV_BITS];
	assign speed_mag = fin.ssat ? mfs_q : squo[DIV_BITS];
	assign steer = (fin.mode == MODE_FIX_HEADING) || (fin.mode == MODE_DRIVE);

	always_comb begin
		turn_c = '0;
		speed_c = '0;
		if (steer && !fin.zero) begin
			turn_c = fin.neg ? -$signed({1'b0, turn_mag}) : $signed({1'b0, turn_mag});
		end
		if (fin.mode == MODE_DRIVE) begin
			speed_c = $signed({1'b0, speed_mag});
		end
	end

	always_ff @(posedge clk) begin
		mode <= fin.mode;
		turn_command <= turn_c;
		speed_command <= speed_c;
		finished <= !steer;
		succeeded <= (fin.mode == MODE_REACHED) && dactive[DIV_BITS];
	end

	assign done = vld_q[LAT-1];
endmodule
